>>> src/cbz_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared types and constants of the cubic bezier trajectory generator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  localparam int POS_BITS    = 20;
  localparam int QUAT_BITS   = 16;
  localparam int CFG_W       = 60;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_DATA_W   = 128;
  localparam int IN_USER_W   = 2;
  localparam int T_STEP_RESET = 66;
  localparam logic [QUAT_BITS-1:0] QUAT_Y_RESET = 16'd16384;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_POST_START = 2'd0,
    REG_PRE_END    = 2'd1,
    REG_END        = 2'd2,
    REG_T_STEP     = 2'd3
  } cfg_reg_t;

  // clear loads operands, enable advances one bit
  typedef struct packed {
    logic clr;
    logic en;
  } step_ctl_t;

endpackage

>>> src/cbz_rmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbz_rmul
// Bit-serial shift-add multiplier for unsigned curve parameter values,
// one multiplier bit per enabled cycle, product rounded half up to the Q1.F format.
// ----------------------------------------------------------------------------
module cbz_rmul #(
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  cbz_pkg::step_ctl_t       ctl,
  input  logic [PARAM_FRAC_BITS:0] a,
  input  logic [PARAM_FRAC_BITS:0] b,
  output logic [PARAM_FRAC_BITS:0] prod
);

  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam logic [TW:0] HALF = (TW + 1)'(1) << (PARAM_FRAC_BITS - 1);

  logic [TW-1:0] acc_r, acc_nxt;
  logic [TW-1:0] low_r, low_nxt;
  logic [TW-1:0] b_sr_r;
  logic [TW:0]   sum;
  logic [TW:0]   low_rnd;
  logic [TW:0]   prod_w;

  always_comb begin
    sum     = {1'b0, acc_r} + (b_sr_r[0] ? {1'b0, a} : '0);
    acc_nxt = sum[TW:1];
    low_nxt = {sum[0], low_r[TW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r  <= '0;
      b_sr_r <= b;
    end else if (ctl.en) begin
      acc_r  <= acc_nxt;
      low_r  <= low_nxt;
      b_sr_r <= {1'b0, b_sr_r[TW-1:1]};
    end
  end

  // product = acc * 2^TW + low, rounded at bit F
  always_comb begin
    low_rnd = {1'b0, low_r} + HALF;
    prod_w  = {acc_r, 1'b0} + (TW + 1)'(low_rnd[TW:PARAM_FRAC_BITS]);
    prod    = prod_w[TW-1:0];
  end

endmodule

>>> src/cbz_coord_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbz_coord_lane
// One coordinate of the curve: sums the four weighted control points one
// weight bit per enabled cycle, then rounds half up and saturates the result.
// ----------------------------------------------------------------------------
module cbz_coord_lane #(
  parameter int COORD_BITS      = 20,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  cbz_pkg::step_ctl_t               ctl,
  input  logic [3:0]                       wbit,
  input  logic [cbz_pkg::POS_BITS-1:0]     p0,
  input  logic [COORD_BITS-1:0]            p1,
  input  logic [COORD_BITS-1:0]            p2,
  input  logic [COORD_BITS-1:0]            p3,
  output logic [COORD_BITS-1:0]            coord
);

  localparam int PW = (COORD_BITS > cbz_pkg::POS_BITS) ? COORD_BITS : cbz_pkg::POS_BITS;
  localparam int AW = PW + 4;
  localparam int NW = PARAM_FRAC_BITS + 3;
  localparam int RW = AW + 3;
  localparam logic [NW:0] HALF = (NW + 1)'(1) << (PARAM_FRAC_BITS - 1);
  localparam logic signed [RW-1:0] CMAX = (RW'(1) << (COORD_BITS - 1)) - RW'(1);
  localparam logic signed [RW-1:0] CMIN = ~CMAX;

  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [NW-1:0]        low_r, low_nxt;
  logic signed [AW-1:0] term0, term1, term2, term3;
  logic signed [AW-1:0] sum;
  logic [NW:0]          low_rnd;
  logic signed [RW-1:0] rnd;

  always_comb begin
    term0   = wbit[0] ? {{(AW - cbz_pkg::POS_BITS){p0[cbz_pkg::POS_BITS-1]}}, p0} : '0;
    term1   = wbit[1] ? {{(AW - COORD_BITS){p1[COORD_BITS-1]}}, p1} : '0;
    term2   = wbit[2] ? {{(AW - COORD_BITS){p2[COORD_BITS-1]}}, p2} : '0;
    term3   = wbit[3] ? {{(AW - COORD_BITS){p3[COORD_BITS-1]}}, p3} : '0;
    sum     = acc_r + term0 + term1 + term2 + term3;
    acc_nxt = sum >>> 1;
    low_nxt = {sum[0], low_r[NW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.en) begin
      acc_r <= acc_nxt;
      low_r <= low_nxt;
    end
  end

  // sum = acc * 2^NW + low, floor of (sum + half) / 2^F
  always_comb begin
    low_rnd = {1'b0, low_r} + HALF;
    rnd     = $signed({acc_r, 3'b000}) +
              $signed({{(RW - 4){1'b0}}, low_rnd[NW:PARAM_FRAC_BITS]});
    if (rnd > CMAX) begin
      coord = CMAX[COORD_BITS-1:0];
    end else if (rnd < CMIN) begin
      coord = CMIN[COORD_BITS-1:0];
    end else begin
      coord = rnd[COORD_BITS-1:0];
    end
  end

endmodule

>>> src/cubic_bezier_trajectory_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_trajectory_generator
// Turns control ticks into points on a cubic bezier curve from the first
// measured pose through three programmed control points.
// ----------------------------------------------------------------------------
// A stop request, or a tick that gives no result, is taken without leaving
// the idle state. A tick that gives a curve point occupies the block from
// acceptance to the next acceptance: two bit-serial multipliers form the
// Bernstein weights in three rounds of PARAM_FRAC_BITS + 1 bits, then three
// coordinate lanes walk the PARAM_FRAC_BITS + 3 weight bits. A finished point
// waits in the output register while the next request is taken; the block
// holds longer while an earlier point is still waiting there.
module cubic_bezier_trajectory_generator #(
  parameter int COORD_BITS      = 20,
  parameter int PARAM_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
  input  logic [cbz_pkg::IN_DATA_W-1:0]     in_tdata,
  // cmd, feedback_valid
  input  logic [cbz_pkg::IN_USER_W-1:0]     in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // cmd_x, cmd_y, cmd_z, hold_w, hold_x, hold_y, hold_z
  output logic [((3*COORD_BITS+4*cbz_pkg::QUAT_BITS+7)/8)*8-1:0] out_tdata,
  input  logic                              cfg_wr_en,
  input  logic [cbz_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cbz_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int TW = PARAM_FRAC_BITS + 1;
  localparam int NW = PARAM_FRAC_BITS + 3;
  localparam int QB = cbz_pkg::QUAT_BITS;
  localparam int PB = cbz_pkg::POS_BITS;
  localparam int OUT_DATA_W = ((3*COORD_BITS + 4*QB + 7) / 8) * 8;
  localparam int PACK_W = (3*COORD_BITS > cbz_pkg::CFG_W) ? 3*COORD_BITS : cbz_pkg::CFG_W;
  localparam int CNT_W = $clog2(NW);
  localparam logic [TW-1:0] ONE_T = TW'(1) << PARAM_FRAC_BITS;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MLOAD = 7'b0000010,
    ST_MRUN  = 7'b0000100,
    ST_MSAVE = 7'b0001000,
    ST_ALOAD = 7'b0010000,
    ST_ARUN  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    MSTEP_SQ   = 2'd0,
    MSTEP_CUBE = 2'd1,
    MSTEP_MIX  = 2'd2
  } mstep_t;

  // configuration
  logic [cbz_pkg::CFG_W-1:0] post_r, pre_r, end_r;
  logic [TW-1:0]             t_step_r;

  // control state
  state_t            state_r, state_nxt;
  mstep_t            step_r, step_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              captured_r, captured_nxt;
  logic [TW-1:0]     t_r, t_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [PB-1:0]     start_r [3];
  logic [QB-1:0]     quat_r [4];
  logic              capture;

  // datapath
  logic [TW-1:0]         t2_r, u2_r;
  logic [NW-1:0]         w_r [4];
  logic [NW-1:0]         wsr_r [4];
  logic [COORD_BITS-1:0] out_cmd_r [3];
  logic [QB-1:0]         out_quat_r [4];

  logic                   in_cmd, in_fb, accept, load_out;
  logic [TW-1:0]          u;
  logic [TW:0]            t_sum;
  logic [TW-1:0]          t_sat;
  logic [TW-1:0]          ma_a, ma_b, mb_a, mb_b, prod_a, prod_b;
  cbz_pkg::step_ctl_t     mul_ctl, lane_ctl;
  logic [3:0]             wbit;
  logic [PACK_W-1:0]      post_pad, pre_pad, end_pad;
  logic [COORD_BITS-1:0]  coord [3];

  assign in_cmd    = in_tuser[0];
  assign in_fb     = in_tuser[1];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata = OUT_DATA_W'({out_quat_r[3], out_quat_r[2], out_quat_r[1], out_quat_r[0],
                                  out_cmd_r[2], out_cmd_r[1], out_cmd_r[0]});

  assign u     = ONE_T - t_r;
  assign t_sum = {1'b0, t_r} + {1'b0, t_step_r};
  assign t_sat = (t_sum > {1'b0, ONE_T}) ? ONE_T : t_sum[TW-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      post_r   <= '0;
      pre_r    <= '0;
      end_r    <= '0;
      t_step_r <= TW'(cbz_pkg::T_STEP_RESET);
    end else if (cfg_wr_en) begin
      unique case (cbz_pkg::cfg_reg_t'(cfg_addr))
        cbz_pkg::REG_POST_START: post_r   <= cfg_wdata;
        cbz_pkg::REG_PRE_END:    pre_r    <= cfg_wdata;
        cbz_pkg::REG_END:        end_r    <= cfg_wdata;
        cbz_pkg::REG_T_STEP:     t_step_r <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // multiplier operands per round
  always_comb begin
    case (step_r)
      MSTEP_CUBE: begin
        ma_a = t2_r; ma_b = t_r; mb_a = u2_r; mb_b = u;
      end
      MSTEP_MIX: begin
        ma_a = t2_r; ma_b = u;   mb_a = u2_r; mb_b = t_r;
      end
      default: begin
        ma_a = t_r;  ma_b = t_r; mb_a = u;    mb_b = u;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    captured_nxt  = captured_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r;
    capture       = 1'b0;
    load_out      = 1'b0;
    mul_ctl       = '0;
    lane_ctl      = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            captured_nxt = 1'b0;
            t_nxt        = '0;
          end else if (captured_r || in_fb) begin
            capture      = !captured_r;
            captured_nxt = 1'b1;
            t_nxt        = t_sat;
            step_nxt     = MSTEP_SQ;
            state_nxt    = ST_MLOAD;
          end
        end
      end
      ST_MLOAD: begin
        mul_ctl.clr = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_MRUN;
      end
      ST_MRUN: begin
        mul_ctl.en = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(TW - 1)) begin
          state_nxt = ST_MSAVE;
        end
      end
      ST_MSAVE: begin
        case (step_r)
          MSTEP_SQ: begin
            step_nxt  = MSTEP_CUBE;
            state_nxt = ST_MLOAD;
          end
          MSTEP_CUBE: begin
            step_nxt  = MSTEP_MIX;
            state_nxt = ST_MLOAD;
          end
          default: begin
            state_nxt = ST_ALOAD;
          end
        endcase
      end
      ST_ALOAD: begin
        lane_ctl.clr = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_ARUN;
      end
      ST_ARUN: begin
        lane_ctl.en = 1'b1;
        cnt_nxt     = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= MSTEP_SQ;
      cnt_r       <= '0;
      captured_r  <= 1'b0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
      start_r[0]  <= '0;
      start_r[1]  <= '0;
      start_r[2]  <= '0;
      quat_r[0]   <= '0;
      quat_r[1]   <= '0;
      quat_r[2]   <= cbz_pkg::QUAT_Y_RESET;
      quat_r[3]   <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      captured_r  <= captured_nxt;
      t_r         <= t_nxt;
      out_valid_r <= out_valid_nxt;
      if (capture) begin
        start_r[0] <= in_tdata[PB-1:0];
        start_r[1] <= in_tdata[2*PB-1:PB];
        start_r[2] <= in_tdata[3*PB-1:2*PB];
        quat_r[0]  <= in_tdata[3*PB+QB-1:3*PB];
        quat_r[1]  <= in_tdata[3*PB+2*QB-1:3*PB+QB];
        quat_r[2]  <= in_tdata[3*PB+3*QB-1:3*PB+2*QB];
        quat_r[3]  <= in_tdata[3*PB+4*QB-1:3*PB+3*QB];
      end
    end
  end

  // weights and output payload
  always_ff @(posedge clk) begin
    if (state_r == ST_MSAVE) begin
      case (step_r)
        MSTEP_SQ: begin
          t2_r <= prod_a;
          u2_r <= prod_b;
        end
        MSTEP_CUBE: begin
          w_r[3] <= NW'(prod_a);
          w_r[0] <= NW'(prod_b);
        end
        default: begin
          w_r[2] <= NW'(prod_a) + (NW'(prod_a) << 1);
          w_r[1] <= NW'(prod_b) + (NW'(prod_b) << 1);
        end
      endcase
    end
    if (lane_ctl.clr) begin
      for (int j = 0; j < 4; j++) begin
        wsr_r[j] <= w_r[j];
      end
    end else if (lane_ctl.en) begin
      for (int j = 0; j < 4; j++) begin
        wsr_r[j] <= {1'b0, wsr_r[j][NW-1:1]};
      end
    end
    if (load_out) begin
      for (int k = 0; k < 3; k++) begin
        out_cmd_r[k] <= coord[k];
      end
      for (int k = 0; k < 4; k++) begin
        out_quat_r[k] <= quat_r[k];
      end
    end
  end

  assign wbit = {wsr_r[3][0], wsr_r[2][0], wsr_r[1][0], wsr_r[0][0]};

  cbz_rmul #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_mul_a (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (ma_a),
    .b   (ma_b),
    .prod(prod_a)
  );

  cbz_rmul #(
    .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
  ) u_mul_b (
    .clk (clk),
    .ctl (mul_ctl),
    .a   (mb_a),
    .b   (mb_b),
    .prod(prod_b)
  );

  // control points beyond the register width read as zero
  assign post_pad = PACK_W'(post_r);
  assign pre_pad  = PACK_W'(pre_r);
  assign end_pad  = PACK_W'(end_r);

  for (genvar k = 0; k < 3; k++) begin : g_lane
    cbz_coord_lane #(
      .COORD_BITS     (COORD_BITS),
      .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .wbit (wbit),
      .p0   (start_r[k]),
      .p1   (post_pad[k*COORD_BITS +: COORD_BITS]),
      .p2   (pre_pad[k*COORD_BITS +: COORD_BITS]),
      .p3   (end_pad[k*COORD_BITS +: COORD_BITS]),
      .coord(coord[k])
    );
  end

endmodule
